### src/obdmp_pkg.sv
// Shared types, constants and character helpers for the multi-PID reply parser.
package obdmp_pkg;

    localparam logic [1:0] UPD_NONE     = 2'd0;
    localparam logic [1:0] UPD_RPM      = 2'd1;
    localparam logic [1:0] UPD_THROTTLE = 2'd2;
    localparam logic [1:0] UPD_SPEED    = 2'd3;

    localparam logic [7:0] PID_RPM      = 8'h0C;
    localparam logic [7:0] PID_SPEED    = 8'h0D;
    localparam logic [7:0] PID_MAF      = 8'h10;
    localparam logic [7:0] PID_THROTTLE = 8'h11;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FOUR  = 8'h34;

    localparam logic [13:0] RECV_MAX    = 14'h3FFF;
    localparam logic [2:0]  LEAD_CHARS  = 3'd3;
    localparam logic [2:0]  LINE_LEN_MAX = 3'd4;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_DIGIT   = 3'd1,
        PH_SPACE   = 3'd2,
        PH_FIRST   = 3'd3,
        PH_CODE_HI = 3'd4,
        PH_CODE_LO = 3'd5,
        PH_DATA    = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        first_frame;
        logic        stopped;
        logic [7:0]  pair_high;
        logic [7:0]  code;
        logic [15:0] data_value;
        logic [2:0]  data_chars;
        logic [13:0] received;
        logic        parsed;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  upd;
        logic [13:0] rpm;
        logic [6:0]  throttle;
        logic [7:0]  speed;
    } feed_result_t;

    // Hex digit value, 16 for anything else.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    // Prefix-only two-digit hex value.
    function automatic logic [7:0] pair_val(input logic [7:0] h, input logic [7:0] l);
        logic [4:0] vh;
        logic [4:0] vl;
        logic [7:0] r;
        vh = hex_val(h);
        vl = hex_val(l);
        if (vh[4])
        begin
            r = 8'd0;
        end
        else if (vl[4])
        begin
            r = {4'd0, vh[3:0]};
        end
        else
        begin
            r = {vh[3:0], vl[3:0]};
        end
        return r;
    endfunction

    function automatic logic [13:0] sat_add(input logic [13:0] a, input logic [2:0] n);
        logic [14:0] s;
        s = {1'b0, a} + {12'd0, n};
        return s[14] ? RECV_MAX : s[13:0];
    endfunction

endpackage

### src/obdmp_feed.sv
// One character step of the reply line parser.
module obdmp_feed (
    input  obdmp_pkg::parse_state_t st,
    input  logic [12:0]             expected,
    input  logic [7:0]              ch,
    output obdmp_pkg::parse_state_t st_next,
    output obdmp_pkg::feed_result_t res
);
    import obdmp_pkg::*;

    logic [7:0]  byte_val;
    logic [15:0] data_shift;
    logic [2:0]  chars_inc;
    logic [2:0]  group_len;
    logic        at_limit;
    logic [14:0] prod;
    logic [16:0] quot_sum;
    logic        first_pair;

    assign byte_val   = pair_val(st.pair_high, ch);
    assign data_shift = {st.data_value[7:0], byte_val};
    assign chars_inc  = st.data_chars + 3'd1;
    assign group_len  = (st.code == PID_RPM || st.code == PID_MAF) ? 3'd4 : 3'd2;
    assign at_limit   = (expected != 13'd0) && (st.received >= {1'b0, expected});
    // floor(x / 255) for x = byte_val * 100, which stays at or below 25500
    assign prod       = {7'd0, byte_val} * 15'd100;
    assign quot_sum   = {2'b00, prod} + {10'd0, prod[14:8]} + 17'd1;
    assign first_pair = (st.phase == PH_FIRST) || (st.phase == PH_DIGIT && ch != CH_COLON);

    always_comb
    begin
        st_next      = st;
        res.upd      = UPD_NONE;
        res.rpm      = data_shift[15:2];
        res.throttle = quot_sum[14:8];
        res.speed    = byte_val;
        if (!st.stopped)
        begin
            if (first_pair)
            begin
                if (st.pair_high == CH_FOUR && ch == CH_ONE)
                begin
                    st_next.first_frame = 1'b1;
                    st_next.received    = sat_add(st.received, 3'd2);
                    st_next.phase       = PH_CODE_HI;
                end
                else if (at_limit)
                begin
                    st_next.stopped = 1'b1;
                end
                else
                begin
                    st_next.code       = byte_val;
                    st_next.received   = sat_add(st.received, 3'd2);
                    st_next.data_chars = 3'd0;
                    st_next.data_value = 16'd0;
                    st_next.phase      = PH_DATA;
                end
            end
            else
            begin
                unique case (st.phase)
                    PH_START:
                    begin
                        if (ch >= CH_ZERO && ch <= CH_NINE)
                        begin
                            st_next.pair_high = ch;
                            st_next.phase     = PH_DIGIT;
                        end
                        else if (ch == CH_SPACE)
                        begin
                            st_next.phase = PH_SPACE;
                        end
                        else
                        begin
                            st_next.pair_high = ch;
                            st_next.phase     = PH_FIRST;
                        end
                    end
                    PH_DIGIT:
                    begin
                        st_next.phase = PH_SPACE;
                    end
                    PH_SPACE:
                    begin
                        if (ch != CH_SPACE)
                        begin
                            st_next.pair_high = ch;
                            st_next.phase     = PH_FIRST;
                        end
                    end
                    PH_CODE_HI:
                    begin
                        if (at_limit)
                        begin
                            st_next.stopped = 1'b1;
                        end
                        else
                        begin
                            st_next.pair_high = ch;
                            st_next.phase     = PH_CODE_LO;
                        end
                    end
                    PH_CODE_LO:
                    begin
                        st_next.code       = byte_val;
                        st_next.received   = sat_add(st.received, 3'd2);
                        st_next.data_chars = 3'd0;
                        st_next.data_value = 16'd0;
                        st_next.phase      = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        st_next.data_chars = chars_inc;
                        if (!st.data_chars[0])
                        begin
                            st_next.pair_high = ch;
                        end
                        else
                        begin
                            st_next.data_value = data_shift;
                            if (chars_inc >= group_len)
                            begin
                                st_next.received = sat_add(st.received, group_len);
                                st_next.phase    = PH_CODE_HI;
                                if (st.code == PID_RPM && st.first_frame)
                                begin
                                    res.upd        = UPD_RPM;
                                    st_next.parsed = 1'b1;
                                end
                                else if (st.code == PID_THROTTLE && st.first_frame)
                                begin
                                    res.upd        = UPD_THROTTLE;
                                    st_next.parsed = 1'b1;
                                end
                                else if (st.code == PID_SPEED)
                                begin
                                    res.upd        = UPD_SPEED;
                                    st_next.parsed = 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        st_next = st;
                    end
                endcase
            end
        end
    end

endmodule

### src/obd_multi_pid_response_parser.sv
// Top level of the mode-01 multi-PID reply parser.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  item     | item_valid / item_ready    | mode, character
//  result   | result_valid / result_ready| rpm, throttle, speed, updated,
//           |                            | line_had_data, count_line
//
//  One item per cycle while item_ready is high; each result appears in the cycle after its item is taken.
//  Each character is parsed as it arrives; the first three characters of a line
//  also feed a running hex value used to spot a count line at end of line.
//  A single result register decouples the sides; item_ready drops only while
//  that register is full and result_ready is low.
//  Reset clears all parse state, counts and values; no clearing pass.
module obd_multi_pid_response_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        mode,
    input  logic [7:0]  character,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [13:0] rpm,
    output logic [6:0]  throttle,
    output logic [7:0]  speed,
    output logic [1:0]  updated,
    output logic        line_had_data,
    output logic        count_line
);
    import obdmp_pkg::*;

    parse_state_t parse_reg;
    parse_state_t parse_next;
    parse_state_t feed_next;
    parse_state_t line_clear;
    feed_result_t feed_res;

    logic [2:0]  line_length_reg;
    logic [11:0] lead_value_reg;
    logic        lead_hex_reg;
    logic [12:0] expected_reg;
    logic [13:0] rpm_reg;
    logic [6:0]  throttle_reg;
    logic [7:0]  speed_reg;
    logic        result_valid_reg;
    logic [1:0]  updated_reg;
    logic        had_reg;
    logic        count_reg;
    logic        accept;
    logic [4:0]  char_hex;
    logic        is_count_line;

    obdmp_feed u_feed (
        .st       (parse_reg),
        .expected (expected_reg),
        .ch       (character),
        .st_next  (feed_next),
        .res      (feed_res)
    );

    assign item_ready    = !result_valid_reg || result_ready;
    assign accept        = item_valid && item_ready;
    assign char_hex      = hex_val(character);
    assign is_count_line = lead_hex_reg && (line_length_reg <= LEAD_CHARS);

    always_comb
    begin
        line_clear            = '0;
        line_clear.phase      = PH_START;
        line_clear.received   = parse_reg.received;
        parse_next            = line_clear;
        if (is_count_line)
        begin
            parse_next.received = 14'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg        <= '{phase: PH_START, default: '0};
            line_length_reg  <= 3'd0;
            lead_value_reg   <= 12'd0;
            lead_hex_reg     <= 1'b1;
            expected_reg     <= 13'd0;
            rpm_reg          <= 14'd0;
            throttle_reg     <= 7'd0;
            speed_reg        <= 8'd0;
            result_valid_reg <= 1'b0;
            updated_reg      <= UPD_NONE;
            had_reg          <= 1'b0;
            count_reg        <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && result_ready && !accept)
            begin
                result_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                result_valid_reg <= 1'b1;
                if (!mode)
                begin
                    parse_reg   <= feed_next;
                    updated_reg <= feed_res.upd;
                    had_reg     <= 1'b0;
                    count_reg   <= 1'b0;
                    unique case (feed_res.upd)
                        UPD_RPM:      rpm_reg      <= feed_res.rpm;
                        UPD_THROTTLE: throttle_reg <= feed_res.throttle;
                        UPD_SPEED:    speed_reg    <= feed_res.speed;
                        default:      rpm_reg      <= rpm_reg;
                    endcase
                    if (line_length_reg < LINE_LEN_MAX)
                    begin
                        line_length_reg <= line_length_reg + 3'd1;
                    end
                    if (line_length_reg < LEAD_CHARS)
                    begin
                        if (char_hex[4])
                        begin
                            lead_hex_reg <= 1'b0;
                        end
                        else
                        begin
                            lead_value_reg <= {lead_value_reg[7:0], char_hex[3:0]};
                        end
                    end
                end
                else
                begin
                    parse_reg       <= parse_next;
                    updated_reg     <= UPD_NONE;
                    line_length_reg <= 3'd0;
                    lead_value_reg  <= 12'd0;
                    lead_hex_reg    <= 1'b1;
                    if (is_count_line)
                    begin
                        expected_reg <= {lead_value_reg, 1'b0};
                        count_reg    <= 1'b1;
                        had_reg      <= 1'b0;
                    end
                    else
                    begin
                        count_reg <= 1'b0;
                        had_reg   <= parse_reg.parsed;
                    end
                end
            end
        end
    end

    assign result_valid  = result_valid_reg;
    assign rpm           = rpm_reg;
    assign throttle      = throttle_reg;
    assign speed         = speed_reg;
    assign updated       = updated_reg;
    assign line_had_data = had_reg;
    assign count_line    = count_reg;

`ifndef SYNTHESIS
    a_count_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(count_reg && (had_reg || updated_reg != UPD_NONE)))
        else $error("count line result carries parse data");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode) |=> (parse_reg.phase == PH_START && line_length_reg == 3'd0))
        else $error("line state not cleared at end of line");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_length_reg <= LINE_LEN_MAX)
        else $error("line length out of range");

    a_throttle_range: assert property (@(posedge clk) disable iff (!rst_n)
        throttle_reg <= 7'd100)
        else $error("throttle above 100 percent");

    a_count_resets_recv: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode && is_count_line) |=> (parse_reg.received == 14'd0 && count_reg))
        else $error("count line did not reset received count");
`endif

endmodule

### dv/tb_obd_multi_pid_response_parser.sv
// Testbench for the multi-PID reply parser: random reply lines in, decoded values checked.
`timescale 1ns / 1ps

module tb_obd_multi_pid_response_parser;
    import obdmp_pkg::*;

    localparam int ITEM_TARGET = 1750;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
    } rx_item_t;

    typedef struct packed {
        logic [13:0] rpm;
        logic [6:0]  throttle;
        logic [7:0]  speed;
        logic [1:0]  updated;
        logic        had;
        logic        cnt;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        mode = 1'b0;
    logic [7:0]  character = 8'h00;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [13:0] rpm;
    logic [6:0]  throttle;
    logic [7:0]  speed;
    logic [1:0]  updated;
    logic        line_had_data;
    logic        count_line;

    rx_item_t char_stream[$];
    reading_t readings_due[$];
    int       queued = 0;
    int       fail_count = 0;
    int       cycles = 0;

    // predicted parser state
    logic [7:0]  lead_buf[3];
    int          line_len;
    phase_t      phase;
    logic        frame41;
    logic        halted;
    logic [7:0]  hi_char;
    logic [7:0]  pid;
    logic [15:0] acc;
    int          nib_cnt;
    int          want_cnt;
    int          got_cnt;
    logic        saw_value;
    logic [13:0] rpm_now;
    logic [6:0]  thr_now;
    logic [7:0]  spd_now;

    obd_multi_pid_response_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .character    (character),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .rpm          (rpm),
        .throttle     (throttle),
        .speed        (speed),
        .updated      (updated),
        .line_had_data(line_had_data),
        .count_line   (count_line)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0");
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c) - int'("A") + 10;
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c) - int'("a") + 10;
        end
        return 16;
    endfunction

    function automatic int pair_value(logic [7:0] h, logic [7:0] l);
        int vh;
        int vl;
        vh = hex_nibble(h);
        vl = hex_nibble(l);
        if (vh > 15)
        begin
            return 0;
        end
        if (vl > 15)
        begin
            return vh;
        end
        return vh * 16 + vl;
    endfunction

    function automatic int group_len(logic [7:0] code);
        return (code == PID_RPM || code == PID_MAF) ? 4 : 2;
    endfunction

    function automatic void bump_recv(int n);
        got_cnt = (got_cnt + n > int'(RECV_MAX)) ? int'(RECV_MAX) : got_cnt + n;
    endfunction

    function automatic logic count_met();
        return want_cnt != 0 && got_cnt >= want_cnt;
    endfunction

    function automatic void begin_pid(logic [7:0] h, logic [7:0] l);
        pid = 8'(pair_value(h, l));
        bump_recv(2);
        nib_cnt = 0;
        acc = 16'd0;
        phase = PH_DATA;
    endfunction

    function automatic void frame_start_pair(logic [7:0] c);
        if (hi_char == CH_FOUR && c == CH_ONE)
        begin
            frame41 = 1'b1;
            bump_recv(2);
            phase = PH_CODE_HI;
        end
        else if (count_met())
        begin
            halted = 1'b1;
        end
        else
        begin
            begin_pid(hi_char, c);
        end
    endfunction

    function automatic logic [1:0] feed_char(logic [7:0] c);
        logic [1:0] upd;
        logic [7:0] byte_v;
        int         len;
        upd = UPD_NONE;
        if (!halted)
        begin
            case (phase)
                PH_START:
                begin
                    if (c >= CH_ZERO && c <= CH_NINE)
                    begin
                        hi_char = c;
                        phase = PH_DIGIT;
                    end
                    else if (c == CH_SPACE)
                    begin
                        phase = PH_SPACE;
                    end
                    else
                    begin
                        hi_char = c;
                        phase = PH_FIRST;
                    end
                end
                PH_DIGIT:
                begin
                    if (c == CH_COLON)
                    begin
                        phase = PH_SPACE;
                    end
                    else
                    begin
                        frame_start_pair(c);
                    end
                end
                PH_SPACE:
                begin
                    if (c != CH_SPACE)
                    begin
                        hi_char = c;
                        phase = PH_FIRST;
                    end
                end
                PH_FIRST:
                begin
                    frame_start_pair(c);
                end
                PH_CODE_HI:
                begin
                    if (count_met())
                    begin
                        halted = 1'b1;
                    end
                    else
                    begin
                        hi_char = c;
                        phase = PH_CODE_LO;
                    end
                end
                PH_CODE_LO:
                begin
                    begin_pid(hi_char, c);
                end
                PH_DATA:
                begin
                    if (nib_cnt % 2 == 0)
                    begin
                        hi_char = c;
                        nib_cnt++;
                    end
                    else
                    begin
                        byte_v = 8'(pair_value(hi_char, c));
                        acc = {acc[7:0], byte_v};
                        nib_cnt++;
                        len = group_len(pid);
                        if (nib_cnt >= len)
                        begin
                            bump_recv(len);
                            phase = PH_CODE_HI;
                            if (pid == PID_RPM && frame41)
                            begin
                                rpm_now = acc[15:2];
                                saw_value = 1'b1;
                                upd = UPD_RPM;
                            end
                            else if (pid == PID_THROTTLE && frame41)
                            begin
                                thr_now = 7'(byte_v * 100 / 255);
                                saw_value = 1'b1;
                                upd = UPD_THROTTLE;
                            end
                            else if (pid == PID_SPEED)
                            begin
                                spd_now = byte_v;
                                saw_value = 1'b1;
                                upd = UPD_SPEED;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        return upd;
    endfunction

    function automatic void new_line();
        line_len = 0;
        phase = PH_START;
        frame41 = 1'b0;
        halted = 1'b0;
        hi_char = 8'h00;
        pid = 8'h00;
        acc = 16'd0;
        nib_cnt = 0;
        saw_value = 1'b0;
    endfunction

    function automatic reading_t decode_item(logic m, logic [7:0] c);
        reading_t   r;
        logic [1:0] u;
        logic       all_hex;
        int         val;
        int         v;
        r = '0;
        if (!m)
        begin
            if (line_len < 3)
            begin
                lead_buf[line_len] = c;
                line_len++;
            end
            else
            begin
                if (line_len == 3)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        u = feed_char(lead_buf[i]);
                        if (u != UPD_NONE)
                        begin
                            r.updated = u;
                        end
                    end
                    line_len = 4;
                end
                u = feed_char(c);
                if (u != UPD_NONE)
                begin
                    r.updated = u;
                end
            end
        end
        else
        begin
            all_hex = line_len <= 3;
            val = 0;
            for (int i = 0; i < 3 && i < line_len; i++)
            begin
                v = hex_nibble(lead_buf[i]);
                if (v > 15)
                begin
                    all_hex = 1'b0;
                end
                else
                begin
                    val = val * 16 + v;
                end
            end
            if (all_hex)
            begin
                want_cnt = (val * 2) & 'h1FFF;
                got_cnt = 0;
                r.cnt = 1'b1;
            end
            else
            begin
                if (line_len <= 3)
                begin
                    for (int i = 0; i < 3 && i < line_len; i++)
                    begin
                        u = feed_char(lead_buf[i]);
                    end
                end
                r.had = saw_value;
            end
            new_line();
        end
        r.rpm = rpm_now;
        r.throttle = thr_now;
        r.speed = spd_now;
        return r;
    endfunction

    // stimulus helpers
    function automatic void push_char(logic [7:0] c);
        rx_item_t it;
        it.mode = 1'b0;
        it.ch = c;
        char_stream.push_back(it);
        queued++;
    endfunction

    function automatic void push_eol();
        rx_item_t it;
        it.mode = 1'b1;
        it.ch = 8'($urandom_range(0, 255));
        char_stream.push_back(it);
        queued++;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i]);
        end
    endfunction

    function automatic logic [7:0] nib_char(logic [3:0] n);
        string digits;
        digits = $urandom_range(0, 1) ? "0123456789abcdef" : "0123456789ABCDEF";
        return digits[n];
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_nibble(c) < 16)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic void push_byte(logic [7:0] v);
        logic [7:0] hc;
        logic [7:0] lc;
        hc = nib_char(v[7:4]);
        lc = nib_char(v[3:0]);
        case ($urandom_range(0, 24))
            0: hc = non_hex();
            1: lc = non_hex();
            default:
            begin
            end
        endcase
        push_char(hc);
        push_char(lc);
    endfunction

    function automatic void gen_frame();
        logic [7:0] code;
        if ($urandom_range(0, 3) == 0)
        begin
            push_char(8'(CH_ZERO + $urandom_range(0, 9)));
            push_char(CH_COLON);
        end
        repeat ($urandom_range(0, 2)) push_char(CH_SPACE);
        if ($urandom_range(0, 4) != 0)
        begin
            push_text("41");
        end
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 5))
                0: code = PID_RPM;
                1: code = PID_SPEED;
                2: code = PID_THROTTLE;
                3: code = PID_MAF;
                default: code = 8'($urandom_range(0, 255));
            endcase
            push_byte(code);
            repeat (group_len(code) / 2) push_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 3)) push_char(nib_char(4'($urandom_range(0, 15))));
        end
        push_eol();
    endfunction

    function automatic void gen_count_line();
        int n;
        n = $urandom_range(0, 3);
        if ($urandom_range(0, 1) != 0)
        begin
            for (int i = 0; i < n; i++)
            begin
                push_char(8'(i == n - 1 ? CH_ZERO + $urandom_range(1, 9) : CH_ZERO));
            end
        end
        else
        begin
            repeat (n) push_char(nib_char(4'($urandom_range(0, 15))));
        end
        push_eol();
    endfunction

    function automatic void gen_short_line();
        int n;
        int bad;
        n = $urandom_range(1, 3);
        bad = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            if (i == bad)
            begin
                push_char(non_hex());
            end
            else
            begin
                push_char($urandom_range(0, 1) ? nib_char(4'($urandom_range(0, 15))) : CH_SPACE);
            end
        end
        push_eol();
    endfunction

    // sender: bursts of items separated by random gaps
    int       burst_left = 0;
    int       gap_left = 0;
    rx_item_t nxt;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            mode <= 1'b0;
            character <= 8'h00;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                readings_due.push_back(decode_item(mode, character));
            end
            if (!item_valid || item_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    item_valid <= 1'b0;
                end
                else if (char_stream.size() != 0)
                begin
                    nxt = char_stream.pop_front();
                    item_valid <= 1'b1;
                    mode <= nxt.mode;
                    character <= nxt.ch;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating stall styles plus a periodic long hold-off
    logic [31:0] rx_cycle = 0;
    int          hold_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            rx_cycle <= 0;
            hold_left <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                result_ready <= 1'b0;
            end
            else if (rx_cycle % 2000 == 400)
            begin
                hold_left <= 160;
                result_ready <= 1'b0;
            end
            else
            begin
                case (rx_cycle[9:8])
                    2'd0: result_ready <= 1'b1;
                    2'd1: result_ready <= ($urandom_range(0, 99) < 80);
                    2'd2: result_ready <= 1'($urandom_range(0, 1));
                    default: result_ready <= (rx_cycle % 5 != 0);
                endcase
            end
        end
    end

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    reading_t head;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (readings_due.size() == 0)
            begin
                $error("result with no item pending");
                fail_count++;
            end
            else
            begin
                head = readings_due.pop_front();
                check_field("rpm", 16'(head.rpm), 16'(rpm));
                check_field("throttle", 16'(head.throttle), 16'(throttle));
                check_field("speed", 16'(head.speed), 16'(speed));
                check_field("updated", 16'(head.updated), 16'(updated));
                check_field("line_had_data", 16'(head.had), 16'(line_had_data));
                check_field("count_line", 16'(head.cnt), 16'(count_line));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int kind;
        lead_buf[0] = 8'h00;
        lead_buf[1] = 8'h00;
        lead_buf[2] = 8'h00;
        new_line();
        want_cnt = 0;
        got_cnt = 0;
        rpm_now = '0;
        thr_now = '0;
        spd_now = '0;

        // directed: empty count line, max rpm, prefixed full throttle, non-hex speed
        push_eol();
        push_text("410CFFFF");
        push_eol();
        push_text("0:4111FF");
        push_eol();
        push_text(" 0D7g");
        push_eol();

        while (queued < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 11)
            begin
                gen_frame();
            end
            else if (kind < 14)
            begin
                gen_count_line();
            end
            else if (kind < 16)
            begin
                gen_short_line();
            end
            else
            begin
                repeat ($urandom_range(0, 8)) push_char(8'($urandom_range(0, 255)));
                push_eol();
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (char_stream.size() != 0 || item_valid || readings_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
src/obdmp_pkg.sv
src/obdmp_feed.sv
src/obd_multi_pid_response_parser.sv
dv/tb_obd_multi_pid_response_parser.sv
